### hw/rtl/spmv_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes for the csr sparse matrix-vector multiply block
// no dependencies; used by the stream interfaces and the top level

package spmv_pkg;

	// x vector store
	localparam int VecDepth = 1024;
	localparam int AddrBits = $clog2(VecDepth);
	localparam int XWidth   = 64;

	// row counter
	localparam int RowBits  = 16;

	// fixed field widths
	localparam int OpW      = 2;
	localparam int IdxW     = 10;
	localparam int ValW     = 32;
	localparam int RowW     = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgW     = 32;

	typedef enum logic [OpW-1:0] {
		OP_LOAD = 2'd0,
		OP_NZ   = 2'd1,
		OP_EOR  = 2'd2
	} op_t;

	localparam logic [CfgIdxW-1:0] REG_ALPHA_RE  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ALPHA_IM  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BETA_RE   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_BETA_IM   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LAMBDA_RE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LAMBDA_IM = 3'd5;

	// 1.0 in q8.24
	localparam logic signed [CfgW-1:0] AlphaReReset = 32'sd16777216;

endpackage

### hw/rtl/spmv_stream_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for input items and result items
// depends on spmv_pkg for field widths

interface spmv_in_if import spmv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OpW-1:0]         op;
	logic [IdxW-1:0]        index;
	logic signed [ValW-1:0] value_re;
	logic signed [ValW-1:0] value_im;

	modport source (output valid, output op, output index, output value_re,
		output value_im, input ready);
	modport sink (input valid, input op, input index, input value_re,
		input value_im, output ready);
endinterface

interface spmv_out_if import spmv_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [RowW-1:0]        row;
	logic signed [ValW-1:0] y_re;
	logic signed [ValW-1:0] y_im;
	logic                   saturated;

	modport source (output valid, output row, output y_re, output y_im,
		output saturated, input ready);
	modport sink (input valid, input row, input y_re, input y_im,
		input saturated, output ready);
endinterface

### hw/rtl/csr_sparse_matrix_vector_multiply.sv
`timescale 1ns / 1ps
// top level: streaming complex csr spmv, y = alpha*a*x - lambda*x[s] + beta*y
// depends on spmv_pkg, spmv_stream_if (spmv_in_if, spmv_out_if) and spmv_ram
//
//   channel   dir   beat contents
//   item      in    op, index, value_re, value_im
//   result    out   row, y_re, y_im, saturated
//   cfg_*     in    cfg_we, cfg_index, cfg_data (write only)
//
// one item is taken every cycle unless back-pressure on the result channel holds the stages; an end-of-row
// beat passes s1 to s7 and the output register, which hold two multiplier levels: x and scale products, then alpha
// times the 48-bit sum split into 24-bit halves, each followed by its adder stage
// reset sets alpha to 1.0, clears the accumulators and row counter; the x store is not
// cleared and needs no clearing pass
// each stage moves on when the next one is empty or moving, so bubbles close up and a
// waiting result does not hold back the stages behind it until they fill

module csr_sparse_matrix_vector_multiply import spmv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	spmv_in_if.sink             item,
	spmv_out_if.source          result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data
);

	localparam logic signed [58:0] YMax = 59'sd2147483647;
	localparam logic signed [58:0] YMin = -59'sd2147483648;

	// truncated q8.24 product of two 32-bit values
	function automatic logic signed [39:0] tmul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return p[63:24];
	endfunction

	// upper half of the accumulator times a scale, already aligned
	function automatic logic signed [55:0] hmul(logic signed [23:0] a, logic signed [31:0] b);
		logic signed [55:0] p;
		p = a * b;
		return p;
	endfunction

	// unsigned lower half of the accumulator times a scale, floored
	function automatic logic signed [32:0] lmul(logic [23:0] a, logic signed [31:0] b);
		logic signed [56:0] p;
		p = $signed({1'b0, a}) * b;
		return p[56:24];
	endfunction

	// ---------------------------------------------------------------------------
	// configuration registers
	logic signed [CfgW-1:0] alpha_re_q, alpha_im_q, beta_re_q, beta_im_q;
	logic signed [CfgW-1:0] lambda_re_q, lambda_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_re_q  <= AlphaReReset;
			alpha_im_q  <= '0;
			beta_re_q   <= '0;
			beta_im_q   <= '0;
			lambda_re_q <= '0;
			lambda_im_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA_RE:  alpha_re_q  <= cfg_data;
				REG_ALPHA_IM:  alpha_im_q  <= cfg_data;
				REG_BETA_RE:   beta_re_q   <= cfg_data;
				REG_BETA_IM:   beta_im_q   <= cfg_data;
				REG_LAMBDA_RE: lambda_re_q <= cfg_data;
				REG_LAMBDA_IM: lambda_im_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------
	// stage handshake: a stage loads when it is empty or its successor loads
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, out_v_q;
	logic en1, en2, en3, en4, en5, en6, en7, en_out;

	assign en_out = !out_v_q || result.ready;
	assign en7    = !v_s7 || en_out;
	assign en6    = !v_s6 || en7;
	assign en5    = !v_s5 || en6;
	assign en4    = !v_s4 || en5;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;

	assign item.ready = en1;

	// ---------------------------------------------------------------------------
	// accept: in-range loads write the x store, loads retire here, nonzeros and end-of-row beats read x
	logic                accept, is_nz, is_eor, in_range, ram_we, ram_re;
	logic [AddrBits-1:0] addr;
	logic [XWidth-1:0]   x_rd;

	assign accept   = item.valid && item.ready;
	assign is_nz    = item.op == OP_NZ;
	assign is_eor   = item.op == OP_EOR;
	assign addr     = AddrBits'(item.index);
	assign in_range = 32'(item.index) < 32'(VecDepth);
	assign ram_we   = accept && (item.op == OP_LOAD) && in_range;
	assign ram_re   = accept && (is_nz || is_eor);

	spmv_ram #(
		.Width (XWidth),
		.Depth (VecDepth)
	) u_x_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata ({item.value_re, item.value_im}),
		.re    (ram_re),
		.raddr (addr),
		.rdata (x_rd)
	);

	// s1: item fields beside the registered x read
	logic                   eor_s1, in_range_s1;
	logic signed [ValW-1:0] vre_s1, vim_s1;

	// s1 operands; a is the matrix value for a nonzero, lambda at end of row
	logic signed [ValW-1:0] x_re, x_im, a_re, a_im;

	assign x_re = in_range_s1 ? $signed(x_rd[63:32]) : '0;
	assign x_im = in_range_s1 ? $signed(x_rd[31:0])  : '0;
	assign a_re = eor_s1 ? lambda_re_q : vre_s1;
	assign a_im = eor_s1 ? lambda_im_q : vim_s1;

	// s2: eight truncated products, a*x and beta*old y
	logic                     eor_s2;
	logic signed [39:0]       a_rr_s2, a_ii_s2, a_ri_s2, a_ir_s2;
	logic signed [39:0]       b_rr_s2, b_ii_s2, b_ri_s2, b_ir_s2;

	// s3: complex products
	logic                     eor_s3;
	logic signed [40:0]       pa_re_s3, pa_im_s3, pb_re_s3, pb_im_s3;

	// s4: accumulator snapshot and the shift and beta terms
	logic signed [47:0]       acc_re_q, acc_im_q;
	logic [RowBits-1:0]       row_count_q;
	logic signed [47:0]       sr_s4, si_s4;
	logic signed [41:0]       c_re_s4, c_im_s4;
	logic [RowBits-1:0]       row_s4;
	logic                     eor_take;

	assign eor_take = en4 && v_s3 && eor_s3;

	// s5: alpha partial products over the split accumulator
	logic signed [55:0]       h_rr_s5, h_ii_s5, h_ri_s5, h_ir_s5;
	logic signed [32:0]       l_rr_s5, l_ii_s5, l_ri_s5, l_ir_s5;
	logic signed [41:0]       c_re_s5, c_im_s5;
	logic [RowBits-1:0]       row_s5;

	// s6: exact floored alpha products
	logic signed [56:0]       m_rr_s6, m_ii_s6, m_ri_s6, m_ir_s6;
	logic signed [41:0]       c_re_s6, c_im_s6;
	logic [RowBits-1:0]       row_s6;

	// s7: full-precision y
	logic signed [58:0]       y_re_s7, y_im_s7;
	logic [RowBits-1:0]       row_s7;

	// output register
	logic [RowW-1:0]          row_q;
	logic signed [ValW-1:0]   y_re_q, y_im_q;
	logic                     sat_q;

	// saturation
	logic                     clip_re, clip_im;
	logic signed [ValW-1:0]   y_re_sat, y_im_sat;

	assign clip_re  = (y_re_s7 > YMax) || (y_re_s7 < YMin);
	assign clip_im  = (y_im_s7 > YMax) || (y_im_s7 < YMin);
	assign y_re_sat = (y_re_s7 > YMax) ? 32'sh7fffffff :
		(y_re_s7 < YMin) ? 32'sh80000000 : y_re_s7[31:0];
	assign y_im_sat = (y_im_s7 > YMax) ? 32'sh7fffffff :
		(y_im_s7 < YMin) ? 32'sh80000000 : y_im_s7[31:0];

	// ---------------------------------------------------------------------------
	// control state: stage valids, accumulators, row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_v_q     <= 1'b0;
			acc_re_q    <= '0;
			acc_im_q    <= '0;
			row_count_q <= '0;
		end else begin
			if (en1) begin
				v_s1 <= accept && (is_nz || is_eor);
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			// nonzeros end at the accumulator, only end-of-row beats go on
			if (en4) begin
				v_s4 <= v_s3 && eor_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
			if (en7) begin
				v_s7 <= v_s6;
			end
			if (en_out) begin
				out_v_q <= v_s7;
			end
			if (en4 && v_s3) begin
				if (eor_s3) begin
					acc_re_q    <= '0;
					acc_im_q    <= '0;
					row_count_q <= row_count_q + 1'b1;
				end else begin
					acc_re_q <= acc_re_q + 48'(pa_re_s3);
					acc_im_q <= acc_im_q + 48'(pa_im_s3);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// payload pipeline
	always_ff @(posedge clk) begin
		if (en1) begin
			eor_s1      <= is_eor;
			in_range_s1 <= in_range;
			vre_s1      <= item.value_re;
			vim_s1      <= item.value_im;
		end
		if (en2) begin
			eor_s2  <= eor_s1;
			a_rr_s2 <= tmul(a_re, x_re);
			a_ii_s2 <= tmul(a_im, x_im);
			a_ri_s2 <= tmul(a_re, x_im);
			a_ir_s2 <= tmul(a_im, x_re);
			b_rr_s2 <= tmul(beta_re_q, vre_s1);
			b_ii_s2 <= tmul(beta_im_q, vim_s1);
			b_ri_s2 <= tmul(beta_re_q, vim_s1);
			b_ir_s2 <= tmul(beta_im_q, vre_s1);
		end
		if (en3) begin
			eor_s3   <= eor_s2;
			pa_re_s3 <= 41'(a_rr_s2) - 41'(a_ii_s2);
			pa_im_s3 <= 41'(a_ri_s2) + 41'(a_ir_s2);
			pb_re_s3 <= 41'(b_rr_s2) - 41'(b_ii_s2);
			pb_im_s3 <= 41'(b_ri_s2) + 41'(b_ir_s2);
		end
		if (en4) begin
			// the sum already holds every nonzero ahead of this beat
			sr_s4   <= acc_re_q;
			si_s4   <= acc_im_q;
			c_re_s4 <= 42'(pb_re_s3) - 42'(pa_re_s3);
			c_im_s4 <= 42'(pb_im_s3) - 42'(pa_im_s3);
			row_s4  <= row_count_q;
		end
		if (en5) begin
			h_rr_s5 <= hmul(sr_s4[47:24], alpha_re_q);
			h_ii_s5 <= hmul(si_s4[47:24], alpha_im_q);
			h_ri_s5 <= hmul(sr_s4[47:24], alpha_im_q);
			h_ir_s5 <= hmul(si_s4[47:24], alpha_re_q);
			l_rr_s5 <= lmul(sr_s4[23:0], alpha_re_q);
			l_ii_s5 <= lmul(si_s4[23:0], alpha_im_q);
			l_ri_s5 <= lmul(sr_s4[23:0], alpha_im_q);
			l_ir_s5 <= lmul(si_s4[23:0], alpha_re_q);
			c_re_s5 <= c_re_s4;
			c_im_s5 <= c_im_s4;
			row_s5  <= row_s4;
		end
		if (en6) begin
			m_rr_s6 <= 57'(h_rr_s5) + 57'(l_rr_s5);
			m_ii_s6 <= 57'(h_ii_s5) + 57'(l_ii_s5);
			m_ri_s6 <= 57'(h_ri_s5) + 57'(l_ri_s5);
			m_ir_s6 <= 57'(h_ir_s5) + 57'(l_ir_s5);
			c_re_s6 <= c_re_s5;
			c_im_s6 <= c_im_s5;
			row_s6  <= row_s5;
		end
		if (en7) begin
			y_re_s7 <= 59'(m_rr_s6) - 59'(m_ii_s6) + 59'(c_re_s6);
			y_im_s7 <= 59'(m_ri_s6) + 59'(m_ir_s6) + 59'(c_im_s6);
			row_s7  <= row_s6;
		end
		if (en_out) begin
			row_q  <= RowW'(row_s7);
			y_re_q <= y_re_sat;
			y_im_q <= y_im_sat;
			sat_q  <= clip_re || clip_im;
		end
	end

	assign result.valid     = out_v_q;
	assign result.row       = row_q;
	assign result.y_re      = y_re_q;
	assign result.y_im      = y_im_q;
	assign result.saturated = sat_q;

	// ---------------------------------------------------------------------------
	// assertions

	// the accumulator starts each row from zero
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		eor_take |=> (acc_re_q == '0) && (acc_im_q == '0))
		else $error("accumulator not cleared after end of row");

	// the row counter steps once per end-of-row beat
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		eor_take |=> row_count_q == RowBits'($past(row_count_q) + 1'b1))
		else $error("row counter did not advance");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!eor_take |=> $stable(row_count_q))
		else $error("row counter moved without end of row");

	// a clipped result sits at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && sat_q |-> (y_re_q == 32'sh7fffffff) || (y_re_q == 32'sh80000000)
			|| (y_im_q == 32'sh7fffffff) || (y_im_q == 32'sh80000000))
		else $error("saturated flag without a clipped component");

	// back-pressure at the input only when the first stage is occupied
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> v_s1)
		else $error("input stalled with an empty first stage");

endmodule

### hw/rtl/spmv_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module spmv_ram #(
	parameter int Width = 64,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
